>>> rtl/cpap_pkg.sv
`default_nettype none
package cpap_pkg;

    localparam int COLUMNS_DEF  = 512;
    localparam int MAX_ROWS_DEF = 512;

    localparam int SUM_W   = 17;
    localparam int PIX_W   = 8;
    localparam int COL_W   = 9;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_ACCUM  = 2'd1;
    localparam logic [1:0] CMD_AVG    = 2'd2;
    localparam logic [1:0] CMD_RENDER = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_ROWS = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FILL_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK      = 2'd2;

    typedef struct packed {
        logic [1:0]       command;
        logic [COL_W-1:0] column;
        logic [PIX_W-1:0] pixel_value;
        logic             row_end;
        logic [PIX_W-1:0] level;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [1:0]       status;
    } t_out_item;

    typedef struct packed {
        logic             fill_mode;
        logic [PIX_W-1:0] bright_value;
        logic [PIX_W-1:0] dark_value;
    } t_cfg;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLR,
        S_ACC_RD,
        S_ACC_WR,
        S_AVG_RD,
        S_AVG_LD,
        S_AVG_DIV,
        S_AVG_WR,
        S_REN_L,
        S_REN_R,
        S_REN_EV,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RD_PTR,
        RD_COL,
        RD_COL_M1
    } t_rd_sel;

    typedef struct packed {
        logic    latch_item;
        logic    rows_clear;
        logic    ptr_clear;
        logic    ptr_inc;
        logic    zero_wr;
        logic    acc_wr;
        logic    avg_wr;
        t_rd_sel rd_sel;
        logic    div_load;
        logic    div_step;
        logic    save_left;
        logic    eval_render;
        logic    out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic row_full;
        logic row_zero;
        logic ptr_last;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

>>> rtl/cpap_ctrl.sv
`default_nettype none
module cpap_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic [1:0]            i_command,
    input  wire cpap_pkg::t_dp_status  i_status,
    output cpap_pkg::t_ctrl_cmd        o_cmd,
    output logic                       o_in_stall
);
    import cpap_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_status.ptr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_command)
                        CMD_CLEAR: n_state = S_CLR;
                        CMD_ACCUM: n_state = i_status.row_full ? S_DONE : S_ACC_RD;
                        CMD_AVG:   n_state = i_status.row_zero ? S_DONE : S_AVG_RD;
                        default:   n_state = S_REN_L;
                    endcase
                end
            end
            S_CLR: begin
                if (i_status.ptr_last) n_state = S_DONE;
            end
            S_ACC_RD:  n_state = S_ACC_WR;
            S_ACC_WR:  n_state = S_DONE;
            S_AVG_RD:  n_state = S_AVG_LD;
            S_AVG_LD:  n_state = S_AVG_DIV;
            S_AVG_DIV: begin
                if (i_status.div_last) n_state = S_AVG_WR;
            end
            S_AVG_WR: begin
                n_state = i_status.ptr_last ? S_DONE : S_AVG_RD;
            end
            S_REN_L:   n_state = S_REN_R;
            S_REN_R:   n_state = S_REN_EV;
            S_REN_EV:  n_state = S_DONE;
            S_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default:   n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.rd_sel = RD_PTR;
        o_in_stall = 1'b1;
        case (r_state)
            S_INIT: begin
                o_cmd.zero_wr = 1'b1;
                o_cmd.ptr_inc = 1'b1;
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.latch_item = 1'b1;
                    o_cmd.ptr_clear  = 1'b1;
                    o_cmd.rows_clear = (i_command == CMD_CLEAR);
                end
            end
            S_CLR: begin
                o_cmd.zero_wr = 1'b1;
                o_cmd.ptr_inc = 1'b1;
            end
            S_ACC_RD: o_cmd.rd_sel = RD_COL;
            S_ACC_WR: o_cmd.acc_wr = 1'b1;
            S_AVG_RD: o_cmd.rd_sel = RD_PTR;
            S_AVG_LD: o_cmd.div_load = 1'b1;
            S_AVG_DIV: o_cmd.div_step = 1'b1;
            S_AVG_WR: begin
                o_cmd.avg_wr  = 1'b1;
                o_cmd.ptr_inc = 1'b1;
            end
            S_REN_L: o_cmd.rd_sel = RD_COL_M1;
            S_REN_R: begin
                o_cmd.rd_sel    = RD_COL;
                o_cmd.save_left = 1'b1;
            end
            S_REN_EV: o_cmd.eval_render = 1'b1;
            S_DONE: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/cpap_dp.sv
`default_nettype none
module cpap_dp #(
    parameter int COLUMNS  = cpap_pkg::COLUMNS_DEF,
    parameter int MAX_ROWS = cpap_pkg::MAX_ROWS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire cpap_pkg::t_ctrl_cmd  i_cmd,
    input  wire cpap_pkg::t_in_item   i_item,
    input  wire cpap_pkg::t_cfg       i_cfg,
    input  wire logic                 i_out_stall,
    output cpap_pkg::t_dp_status      o_status,
    output logic                      o_out_valid,
    output cpap_pkg::t_out_item       o_out_item
);
    import cpap_pkg::*;

    localparam int AW = $clog2(COLUMNS);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int XW = ((AW > COL_W) ? AW : COL_W) + 1;

    logic [SUM_W-1:0] mem [COLUMNS];

    t_in_item          r_item;
    logic [AW-1:0]     r_ptr;
    logic [RW-1:0]     r_row_count;
    logic [SUM_W-1:0]  r_rd_data;
    logic [SUM_W-1:0]  r_left;
    logic [RW-1:0]     r_rem;
    logic [SUM_W-1:0]  r_quot;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [PIX_W-1:0]  r_res_pixel;
    logic [1:0]        r_res_status;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [XW-1:0]     col_x;
    logic              in_range;
    logic [AW-1:0]     col_addr;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [SUM_W-1:0]  wr_data;
    logic [SUM_W:0]    acc_sum;
    logic [SUM_W-1:0]  acc_sat;
    logic [RW:0]       rem_sh;
    logic [RW:0]       rem_diff;
    logic              div_bit;
    logic [SUM_W-1:0]  lo_val;
    logic [SUM_W-1:0]  hi_val;
    logic [SUM_W-1:0]  lvl_x;
    logic              line_hit;
    logic              fill_hit;
    logic              bright;
    logic              row_full;
    logic              row_zero;
    logic              out_free;

    assign col_x    = XW'(r_item.column);
    assign in_range = col_x < XW'(COLUMNS);
    assign col_addr = col_x[AW-1:0];
    assign row_full = r_row_count >= RW'(MAX_ROWS);
    assign row_zero = r_row_count == '0;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_COL:    rd_addr = col_addr;
            RD_COL_M1: rd_addr = col_addr - AW'(1);
            default:   rd_addr = r_ptr;
        endcase
    end

    assign acc_sum = {1'b0, r_rd_data} + (SUM_W + 1)'(r_item.pixel_value);
    assign acc_sat = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ptr;
        wr_data = '0;
        if (i_cmd.zero_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.acc_wr) begin
            wr_en   = in_range;
            wr_addr = col_addr;
            wr_data = acc_sat;
        end else if (i_cmd.avg_wr) begin
            wr_en   = 1'b1;
            wr_data = r_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // restoring division, one quotient bit per cycle
    assign rem_sh   = {r_rem, r_quot[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_row_count};
    assign div_bit  = rem_sh >= {1'b0, r_row_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_quot    <= r_rd_data;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quot    <= {r_quot[SUM_W-2:0], div_bit};
            r_rem     <= div_bit ? rem_diff[RW-1:0] : rem_sh[RW-1:0];
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
    end

    assign lo_val   = (r_left < r_rd_data) ? r_left : r_rd_data;
    assign hi_val   = (r_left < r_rd_data) ? r_rd_data : r_left;
    assign lvl_x    = SUM_W'(r_item.level);
    assign line_hit = (lvl_x <= hi_val) && ((lvl_x > lo_val) || (lvl_x == hi_val));
    assign fill_hit = r_rd_data >= lvl_x;
    assign bright   = (r_item.column == '0) ||
                      (in_range && (i_cfg.fill_mode ? fill_hit : line_hit));

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_item) begin
            r_item      <= i_item;
            r_res_pixel <= '0;
            if (i_item.command == CMD_ACCUM && row_full) begin
                r_res_status <= STATUS_FULL;
            end else if (i_item.command == CMD_AVG && row_zero) begin
                r_res_status <= STATUS_NO_ROWS;
            end else begin
                r_res_status <= STATUS_OK;
            end
        end else if (i_cmd.eval_render) begin
            r_res_pixel <= bright ? i_cfg.bright_value : i_cfg.dark_value;
        end
        if (i_cmd.save_left) begin
            r_left <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_row_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ptr_clear) begin
                r_ptr <= '0;
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= (r_ptr == AW'(COLUMNS - 1)) ? '0 : r_ptr + AW'(1);
            end
            if (i_cmd.rows_clear) begin
                r_row_count <= '0;
            end else if (i_cmd.acc_wr && r_item.row_end) begin
                r_row_count <= r_row_count + RW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.pixel  <= r_res_pixel;
            r_out.status <= r_res_status;
        end
    end

    assign o_status.row_full = row_full;
    assign o_status.row_zero = row_zero;
    assign o_status.ptr_last = r_ptr == AW'(COLUMNS - 1);
    assign o_status.div_last = r_div_cnt == DIV_CNT_W'(SUM_W - 1);
    assign o_status.out_free = out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

>>> rtl/column_profile_average_plot_top.sv
`default_nettype none
// Column profile and plot renderer. Accumulate adds a pixel to its column sum
// (saturating) and counts a row on row_end; average divides every column sum
// by the row count; render returns one plot pixel; clear zeroes sums and count.
// Every command yields exactly one result transaction. Items are processed one
// at a time through a column store with one registered read and one write port.
// Accumulate reads a column sum and writes it back; render reads two neighbouring
// column sums and then evaluates the pixel; clear sweeps every column; average
// reads, divides and writes back each column in turn, using a 17-step
// shift-subtract divider run once per column. An accumulate at full row count
// or an average with no rows answers without touching the column store.
// After reset the block sweeps the column store to zero before taking input.
// A finished result sits in an output register, so the next transaction can
// be taken while it waits. Configuration writes are taken at any time.
module column_profile_average_plot_top #(
    parameter int COLUMNS  = cpap_pkg::COLUMNS_DEF,
    parameter int MAX_ROWS = cpap_pkg::MAX_ROWS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire cpap_pkg::t_in_item                    i_in_data,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output cpap_pkg::t_out_item                        o_out_data,
    input  wire logic                                  i_cfg_we,
    input  wire logic [cpap_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [cpap_pkg::CFG_W-1:0]            i_cfg_data
);
    import cpap_pkg::*;

    t_cfg       r_cfg;
    t_ctrl_cmd  cmd;
    t_dp_status dp_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fill_mode    <= 1'b1;
            r_cfg.bright_value <= '1;
            r_cfg.dark_value   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FILL_MODE: r_cfg.fill_mode    <= i_cfg_data[0];
                CFG_BRIGHT:    r_cfg.bright_value <= i_cfg_data[PIX_W-1:0];
                CFG_DARK:      r_cfg.dark_value   <= i_cfg_data[PIX_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    cpap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_data.command),
        .i_status   (dp_status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    cpap_dp #(
        .COLUMNS  (COLUMNS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_in_data),
        .i_cfg       (r_cfg),
        .i_out_stall (i_out_stall),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_data)
    );

endmodule
`default_nettype wire
